// File: src/delimited_frame_extractor_unit_assert.svh
// Assertion macros for the delimited frame extractor
`ifndef DELIMITED_FRAME_EXTRACTOR_UNIT_ASSERT_SVH
`define DELIMITED_FRAME_EXTRACTOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dfe_pkg.sv
// Shared types and constants for the delimited frame extractor
package dfe_pkg;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_COMPLETE   = 2'd1,
        EV_INCOMPLETE = 2'd2
    } event_t;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_SEQ       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_LEN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_SEQ         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_LEN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_SIZE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_INCOMPLETE = 3'd6;

    localparam int CFG_DATA_W = 64;
    localparam int SEQ_W      = 64;
    localparam int LEN_W      = 4;
    localparam int BSIZE_W    = 13;
    localparam int SCOUNT_W   = 5;

    localparam logic [BSIZE_W-1:0]  BUF_SIZE_RST   = 13'd4096;
    localparam logic [LEN_W-1:0]    LEN_RST        = 4'd1;
    localparam logic [SCOUNT_W-1:0] SLOT_COUNT_RST = 5'd1;

endpackage

// File: src/delimited_frame_extractor_unit.sv
// Delimited frame extractor: start/end delimiter deframer over a ring of frame slots
//
// Usage:
//  - Input channel (in_valid / in_stall / rx_byte): one received byte per item.
//  - Output channel (out_valid / out_stall / payload): exactly one result per byte,
//    giving the byte, its slot and offset, and any frame event with its length.
//  - Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes
//    one register per handshake; cfg_ready is always high. Write only while idle.
//  - Path: a byte accepted is held in the input register, then loaded into the
//    result register, from which the receiver takes it.
//  - Throughput: one item per cycle while out_stall is low, set by the combinational
//    delimiter compare and buffer update between input and result register.
//  - Receiver stall: the result register holds; the input register accepts
//    while it is empty or the result register is free or being emptied, so
//    in_stall rises only once both registers hold an item and out_stall is high.
//  - Reset: registers return to their reset values, hunting for the start
//    delimiter on slot zero with an empty buffer and an all-zero history.
module delimited_frame_extractor_unit #(
    parameter int MAX_SEQ_LEN  = 8,
    parameter int MAX_BUF_SIZE = 4096,
    parameter int MAX_SLOTS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      stored_byte,
    output logic [3:0]                      store_slot,
    output logic [11:0]                     store_offset,
    output logic [1:0]                      event_res,
    output logic [12:0]                     event_length,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dfe_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int WINW = 8 * MAX_SEQ_LEN;
    localparam int FW   = $clog2(MAX_BUF_SIZE + 1);
    localparam int BCW  = (FW > dfe_pkg::BSIZE_W) ? FW : dfe_pkg::BSIZE_W;
    localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SCW  = (SW + 1 > dfe_pkg::SCOUNT_W) ? SW + 1 : dfe_pkg::SCOUNT_W;

    localparam logic [dfe_pkg::LEN_W-1:0] MAX_LEN_W  = dfe_pkg::LEN_W'(MAX_SEQ_LEN);
    localparam logic [BCW-1:0]            MAX_BUF_W  = BCW'(MAX_BUF_SIZE);
    localparam logic [SCW-1:0]            MAX_SLOT_W = SCW'(MAX_SLOTS);

    // configuration registers
    logic [dfe_pkg::SEQ_W-1:0]    start_seq_reg;
    logic [dfe_pkg::LEN_W-1:0]    start_len_reg;
    logic [dfe_pkg::SEQ_W-1:0]    end_seq_reg;
    logic [dfe_pkg::LEN_W-1:0]    end_len_reg;
    logic [dfe_pkg::BSIZE_W-1:0]  buf_size_reg;
    logic [dfe_pkg::SCOUNT_W-1:0] slot_count_reg;
    logic                         pass_incomplete_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    // deframer state
    logic [WINW-1:0] win_reg;
    logic [WINW-1:0] win_next;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic            in_frame_reg;
    logic            in_frame_next;
    logic [SW-1:0]   slot_reg;
    logic [SW-1:0]   slot_next;

    // result register
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic [3:0]           out_slot_reg;
    logic [11:0]          out_offset_reg;
    dfe_pkg::event_t      out_event_reg;
    logic [12:0]          out_length_reg;
    dfe_pkg::event_t      event_next;
    logic [FW-1:0]        length_next;

    logic                       out_free;
    logic                       s1_move;
    logic                       in_accept;
    logic [FW-1:0]              fill_inc;
    logic [dfe_pkg::LEN_W-1:0]  start_len_eff;
    logic [dfe_pkg::LEN_W-1:0]  end_len_eff;
    logic                       start_hit;
    logic                       end_hit;
    logic [BCW-1:0]             size_eff;
    logic [SCW-1:0]             count_eff;
    logic [SCW-1:0]             slot_plus;
    logic [SW-1:0]              slot_adv;
    logic                       overflow;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_seq_reg       <= '0;
            start_len_reg       <= dfe_pkg::LEN_RST;
            end_seq_reg         <= '0;
            end_len_reg         <= dfe_pkg::LEN_RST;
            buf_size_reg        <= dfe_pkg::BUF_SIZE_RST;
            slot_count_reg      <= dfe_pkg::SLOT_COUNT_RST;
            pass_incomplete_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dfe_pkg::REG_START_SEQ:
                    start_seq_reg <= cfg_data;
                dfe_pkg::REG_START_LEN:
                    start_len_reg <= cfg_data[dfe_pkg::LEN_W-1:0];
                dfe_pkg::REG_END_SEQ:
                    end_seq_reg <= cfg_data;
                dfe_pkg::REG_END_LEN:
                    end_len_reg <= cfg_data[dfe_pkg::LEN_W-1:0];
                dfe_pkg::REG_BUF_SIZE:
                    buf_size_reg <= cfg_data[dfe_pkg::BSIZE_W-1:0];
                dfe_pkg::REG_SLOT_COUNT:
                    slot_count_reg <= cfg_data[dfe_pkg::SCOUNT_W-1:0];
                dfe_pkg::REG_PASS_INCOMPLETE:
                    pass_incomplete_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // effective lengths, size and slot count
    always_comb
    begin
        if (start_len_reg == '0)
            start_len_eff = dfe_pkg::LEN_W'(1);
        else if (start_len_reg > MAX_LEN_W)
            start_len_eff = MAX_LEN_W;
        else
            start_len_eff = start_len_reg;

        if (end_len_reg == '0)
            end_len_eff = dfe_pkg::LEN_W'(1);
        else if (end_len_reg > MAX_LEN_W)
            end_len_eff = MAX_LEN_W;
        else
            end_len_eff = end_len_reg;

        if (buf_size_reg == '0)
            size_eff = BCW'(1);
        else if (BCW'(buf_size_reg) > MAX_BUF_W)
            size_eff = MAX_BUF_W;
        else
            size_eff = BCW'(buf_size_reg);

        if (slot_count_reg == '0)
            count_eff = SCW'(1);
        else if (SCW'(slot_count_reg) > MAX_SLOT_W)
            count_eff = MAX_SLOT_W;
        else
            count_eff = SCW'(slot_count_reg);
    end

    // delimiter suffix compare over the byte window
    always_comb
    begin
        win_next  = WINW'({win_reg, s1_byte_reg});
        fill_inc  = fill_reg + FW'(1);
        start_hit = (fill_inc >= FW'(start_len_eff));
        end_hit   = (fill_inc >= FW'(end_len_eff));
        for (int k = 0; k < MAX_SEQ_LEN; k++)
        begin
            if (dfe_pkg::LEN_W'(k) < start_len_eff
                && win_next[8*k +: 8] != start_seq_reg[8*k +: 8])
                start_hit = 1'b0;
            if (dfe_pkg::LEN_W'(k) < end_len_eff
                && win_next[8*k +: 8] != end_seq_reg[8*k +: 8])
                end_hit = 1'b0;
        end
    end

    // next state and event
    always_comb
    begin
        slot_plus     = SCW'(slot_reg) + SCW'(1);
        slot_adv      = (slot_plus >= count_eff) ? '0 : SW'(slot_plus);
        overflow      = (BCW'(fill_inc) >= size_eff);
        fill_next     = fill_inc;
        in_frame_next = in_frame_reg;
        slot_next     = slot_reg;
        event_next    = dfe_pkg::EV_NONE;
        length_next   = '0;

        if (!in_frame_reg && start_hit)
        begin
            in_frame_next = 1'b1;
            fill_next     = '0;
        end
        else if (in_frame_reg && end_hit)
        begin
            event_next    = dfe_pkg::EV_COMPLETE;
            length_next   = fill_inc - FW'(end_len_eff);
            slot_next     = slot_adv;
            in_frame_next = 1'b0;
            fill_next     = '0;
        end
        else if (overflow)
        begin
            if (in_frame_reg && pass_incomplete_reg)
            begin
                event_next  = dfe_pkg::EV_INCOMPLETE;
                length_next = fill_inc;
                slot_next   = slot_adv;
            end
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_byte_reg <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            fill_reg     <= '0;
            in_frame_reg <= 1'b0;
            slot_reg     <= '0;
        end
        else if (s1_move)
        begin
            win_reg      <= win_next;
            fill_reg     <= fill_next;
            in_frame_reg <= in_frame_next;
            slot_reg     <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_byte_reg   <= s1_byte_reg;
            out_slot_reg   <= 4'(slot_reg);
            out_offset_reg <= 12'(fill_reg);
            out_event_reg  <= event_next;
            out_length_reg <= 13'(length_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign stored_byte  = out_byte_reg;
    assign store_slot   = out_slot_reg;
    assign store_offset = out_offset_reg;
    assign event_res    = out_event_reg;
    assign event_length = out_length_reg;

`include "delimited_frame_extractor_unit_assert.svh"

    `DFE_ASSERT_NOW(a_no_event_zero_len,
        out_valid_reg && out_event_reg == dfe_pkg::EV_NONE,
        out_length_reg == '0, "length without an event")

    `DFE_ASSERT_NOW(a_slot_in_ring, 1'b1,
        SCW'(slot_reg) < MAX_SLOT_W, "slot index beyond the ring")

    `DFE_ASSERT_NOW(a_fill_in_buffer, 1'b1,
        BCW'(fill_reg) < MAX_BUF_W, "fill count beyond the buffer")

    `DFE_ASSERT_NEXT(a_item_reaches_output, s1_move,
        out_valid_reg, "item lost between input and result register")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the delimited frame extractor: predicted results vs. the block
`timescale 1ns / 1ps

module testbench;

    localparam int SEQ_MAX      = 8;
    localparam int SIZE_MAX     = 4096;
    localparam int RING_MAX     = 16;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 200;
    localparam int TAIL_CYCLES  = 8;
    localparam int LONG_PAYLOAD = 62;
    localparam logic [dfe_pkg::CFG_IDX_W-1:0] REG_UNUSED = '1;

    typedef struct {
        logic [7:0]      data;
        logic [3:0]      slot;
        logic [11:0]     offset;
        dfe_pkg::event_t ev;
        logic [12:0]     len;
    } store_rec_t;

    class frame_scoreboard;
        logic [63:0]                  start_pat;
        logic [dfe_pkg::LEN_W-1:0]    start_n;
        logic [63:0]                  end_pat;
        logic [dfe_pkg::LEN_W-1:0]    end_n;
        logic [dfe_pkg::BSIZE_W-1:0]  slot_size;
        logic [dfe_pkg::SCOUNT_W-1:0] ring_len;
        logic                         keep_partial;
        logic [55:0]                  history;
        int                           fill;
        bit                           framing;
        int                           slot;
        store_rec_t                   pending_stores[$];
        int                           mismatches;

        function new();
            start_pat    = '0;
            start_n      = dfe_pkg::LEN_RST;
            end_pat      = '0;
            end_n        = dfe_pkg::LEN_RST;
            slot_size    = dfe_pkg::BUF_SIZE_RST;
            ring_len     = dfe_pkg::SLOT_COUNT_RST;
            keep_partial = 1'b0;
            history      = '0;
            fill         = 0;
            framing      = 1'b0;
            slot         = 0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [dfe_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                dfe_pkg::REG_START_SEQ:       start_pat    = val;
                dfe_pkg::REG_START_LEN:       start_n      = val[dfe_pkg::LEN_W-1:0];
                dfe_pkg::REG_END_SEQ:         end_pat      = val;
                dfe_pkg::REG_END_LEN:         end_n        = val[dfe_pkg::LEN_W-1:0];
                dfe_pkg::REG_BUF_SIZE:        slot_size    = val[dfe_pkg::BSIZE_W-1:0];
                dfe_pkg::REG_SLOT_COUNT:      ring_len     = val[dfe_pkg::SCOUNT_W-1:0];
                dfe_pkg::REG_PASS_INCOMPLETE: keep_partial = val[0];
                default: ;
            endcase
        endfunction

        function int clamp_len(logic [dfe_pkg::LEN_W-1:0] n);
            if (n == 0)
                return 1;
            if (n > SEQ_MAX)
                return SEQ_MAX;
            return int'(n);
        endfunction

        function int clamp_size();
            if (slot_size == 0)
                return 1;
            if (slot_size > SIZE_MAX)
                return SIZE_MAX;
            return int'(slot_size);
        endfunction

        function bit tail_equals(logic [63:0] window, logic [63:0] pat,
                                 logic [dfe_pkg::LEN_W-1:0] nreg);
            int          n;
            logic [63:0] mask;
            n = clamp_len(nreg);
            mask = (n >= 8) ? '1 : (64'd1 << (8 * n)) - 64'd1;
            if (fill < n)
                return 1'b0;
            return (window & mask) == (pat & mask);
        endfunction

        function void bump_slot();
            int cnt;
            cnt = (ring_len == 0) ? 1 : (ring_len > RING_MAX) ? RING_MAX : int'(ring_len);
            slot = (slot + 1 >= cnt) ? 0 : slot + 1;
        endfunction

        function void note_rx(logic [7:0] b);
            logic [63:0] window;
            store_rec_t  r;
            int          sz;
            bit          hit;
            window   = {history, b};
            r.data   = b;
            r.slot   = 4'(slot);
            r.offset = 12'(fill);
            r.ev     = dfe_pkg::EV_NONE;
            r.len    = '0;
            sz       = clamp_size();
            hit      = 1'b0;
            history  = window[55:0];
            fill++;
            if (!framing) begin
                if (tail_equals(window, start_pat, start_n)) begin
                    framing = 1'b1;
                    fill    = 0;
                    hit     = 1'b1;
                end
            end
            else if (tail_equals(window, end_pat, end_n)) begin
                r.ev    = dfe_pkg::EV_COMPLETE;
                r.len   = 13'(fill - clamp_len(end_n));
                bump_slot();
                framing = 1'b0;
                fill    = 0;
                hit     = 1'b1;
            end
            if (!hit && fill >= sz) begin
                if (framing && keep_partial) begin
                    r.ev  = dfe_pkg::EV_INCOMPLETE;
                    r.len = 13'(fill);
                    bump_slot();
                end
                fill = 0;
            end
            pending_stores.push_back(r);
        endfunction

        function void check_store(store_rec_t got);
            store_rec_t exp_rec;
            if (pending_stores.size() == 0) begin
                $error("unexpected item: stored_byte %0h slot %0d", got.data, got.slot);
                mismatches++;
                return;
            end
            exp_rec = pending_stores.pop_front();
            if (got.data !== exp_rec.data) begin
                $error("stored_byte: expected %0h, actual %0h", exp_rec.data, got.data);
                mismatches++;
            end
            if (got.slot !== exp_rec.slot) begin
                $error("store_slot: expected %0d, actual %0d", exp_rec.slot, got.slot);
                mismatches++;
            end
            if (got.offset !== exp_rec.offset) begin
                $error("store_offset: expected %0d, actual %0d", exp_rec.offset, got.offset);
                mismatches++;
            end
            if (got.ev !== exp_rec.ev) begin
                $error("event_res: expected %0d, actual %0d", exp_rec.ev, got.ev);
                mismatches++;
            end
            if (got.len !== exp_rec.len) begin
                $error("event_length: expected %0d, actual %0d", exp_rec.len, got.len);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_stores.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [7:0]                     rx_byte = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [7:0]                     stored_byte;
    logic [3:0]                     store_slot;
    logic [11:0]                    store_offset;
    logic [1:0]                     event_res;
    logic [12:0]                    event_length;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    frame_scoreboard sb = new();

    int          snd_gap_pct = 0;
    int          rcv_gap_pct = 0;
    int          hold_cycles = 0;
    int          rx_count = 0;

    logic [63:0]                  st_seq;
    logic [dfe_pkg::LEN_W-1:0]    st_len;
    logic [63:0]                  en_seq;
    logic [dfe_pkg::LEN_W-1:0]    en_len;
    logic [dfe_pkg::BSIZE_W-1:0]  bsize;
    logic [dfe_pkg::SCOUNT_W-1:0] scount;
    logic                         pinc;

    delimited_frame_extractor_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .stored_byte  (stored_byte),
        .store_slot   (store_slot),
        .store_offset (store_offset),
        .event_res    (event_res),
        .event_length (event_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rcv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        store_rec_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.data   = stored_byte;
            got.slot   = store_slot;
            got.offset = store_offset;
            got.ev     = dfe_pkg::event_t'(event_res);
            got.len    = event_length;
            sb.check_store(got);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        rx_byte  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_rx(b);
        rx_count++;
        while ($urandom_range(0, 99) < snd_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [dfe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting();
        write_cfg(dfe_pkg::REG_START_SEQ, st_seq);
        write_cfg(dfe_pkg::REG_START_LEN, 64'(st_len));
        write_cfg(dfe_pkg::REG_END_SEQ, en_seq);
        write_cfg(dfe_pkg::REG_END_LEN, 64'(en_len));
        write_cfg(dfe_pkg::REG_BUF_SIZE, 64'(bsize));
        write_cfg(dfe_pkg::REG_SLOT_COUNT, 64'(scount));
        write_cfg(dfe_pkg::REG_PASS_INCOMPLETE, 64'(pinc));
        // out-of-range index must leave every register alone
        write_cfg(REG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_setting(input int p);
        st_seq = {$urandom, $urandom};
        en_seq = {$urandom, $urandom};
        case (p)
            0:
            begin
                st_len = 4'd1; en_len = 4'd1; bsize = 13'd4096; scount = 5'd16; pinc = 1'b1;
            end
            1:
            begin
                st_len = 4'd8; en_len = 4'd8; bsize = 13'd16; scount = 5'd3; pinc = 1'b0;
            end
            2:
            begin
                st_len = 4'($urandom_range(1, 4));
                en_len = 4'($urandom_range(1, 4));
                bsize  = 13'($urandom_range(8, 64));
                scount = 5'd1;
                pinc   = 1'b1;
            end
            3:
            begin
                st_len = 4'd15; en_len = 4'd0; bsize = 13'd8191; scount = 5'd31; pinc = 1'b1;
            end
            4:
            begin
                st_len = 4'd1; en_len = 4'd1; bsize = 13'd1; scount = 5'd0; pinc = 1'b0;
            end
            default:
            begin
                st_len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 3));
                en_len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 3));
                bsize  = 13'($urandom_range(2, 100));
                scount = 5'($urandom_range(0, 31));
                pinc   = 1'($urandom);
            end
        endcase
    endtask

    // noise, start delimiter, payload, end delimiter; delimiters sometimes cut short
    task automatic send_frame();
        int n;
        int cut;
        int plen;
        int sz;
        sz = sb.clamp_size();
        if ($urandom_range(0, 99) < 10)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        n = sb.clamp_len(st_len);
        cut = ($urandom_range(0, 99) < 12) ? $urandom_range(1, n) : 0;
        for (int i = n - 1; i >= cut; i--)
            send_byte(st_seq[8 * i +: 8]);
        plen = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
             : $urandom_range(0, (sz > LONG_PAYLOAD) ? LONG_PAYLOAD : sz + 2);
        repeat (plen) send_byte(8'($urandom));
        n = sb.clamp_len(en_len);
        cut = ($urandom_range(0, 99) < 10) ? $urandom_range(1, n) : 0;
        for (int i = n - 1; i >= cut; i--)
            send_byte(en_seq[8 * i +: 8]);
    endtask

    initial
    begin
        logic [7:0] seq_bytes[$];
        int         base;
        bit         held;
        bit         paused;

        held   = 1'b0;
        paused = 1'b0;
        snd_gap_pct = 6;
        rcv_gap_pct = 57;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero delimiters, one slot
        seq_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF};
        foreach (seq_bytes[i])
            send_byte(seq_bytes[i]);
        drain();

        // zero lengths, tiny buffer, zero slot count: overflows and match on a full buffer
        st_seq = 64'h7E; st_len = 4'd0; en_seq = 64'h7E; en_len = 4'd0;
        bsize = 13'd3; scount = 5'd0; pinc = 1'b1;
        apply_setting();
        seq_bytes = '{8'h7E, 8'h7E, 8'h11, 8'h22, 8'h7E, 8'h01, 8'h02, 8'h03, 8'h7E};
        foreach (seq_bytes[i])
            send_byte(seq_bytes[i]);
        drain();

        // saturating end length, size and slot count; end delimiter longer than the fill
        st_seq = 64'hFF; st_len = 4'd1; en_seq = '1; en_len = 4'd15;
        bsize = 13'd5000; scount = 5'd17; pinc = 1'b0;
        apply_setting();
        repeat (10) send_byte(8'hFF);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 3)
            begin
                snd_gap_pct = 6;
                rcv_gap_pct = 57;
            end
            else if (p < 6)
            begin
                snd_gap_pct = 57;
                rcv_gap_pct = 6;
            end
            else
            begin
                snd_gap_pct = 0;
                rcv_gap_pct = 0;
            end
            drain();
            pick_setting(p);
            apply_setting();
            base = rx_count;
            while (rx_count - base < PHASE_ITEMS)
            begin
                send_frame();
                if (p == 1 && !held && rx_count - base >= 40)
                begin
                    hold_cycles = 300;
                    held = 1'b1;
                end
                if (p == 4 && !paused && rx_count - base >= 100)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[delimited_frame_extractor_unit] OK");
        else
            $display("[delimited_frame_extractor_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[delimited_frame_extractor_unit] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/dfe_pkg.sv
src/delimited_frame_extractor_unit.sv
dv/testbench.sv
